### hdl/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared widths, codes and CRC helpers for the framed packet receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned IDX_W       = 9;
  localparam int unsigned PLEN_W      = 10;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned GAP_W       = 17;
  localparam int unsigned CRC_W       = 32;

  localparam int unsigned DEFAULT_MAX_PAYLOAD = 512;

  localparam logic [CFG_W-1:0] STALL_LIMIT_RESET = 16'd100;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [BYTE_W-1:0] SYNC_A = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_B = 8'hAA;
  localparam logic [31:0]       MAGIC  = {SYNC_A, SYNC_B, SYNC_A, SYNC_B};

  // frame types that are accepted after the header
  localparam logic [BYTE_W-1:0] TYPE_CMD    = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_DATA   = 8'h02;
  localparam logic [BYTE_W-1:0] TYPE_STATUS = 8'h03;
  localparam logic [BYTE_W-1:0] TYPE_LOG    = 8'h04;
  localparam logic [BYTE_W-1:0] TYPE_EXT_A  = 8'h81;
  localparam logic [BYTE_W-1:0] TYPE_EXT_B  = 8'h82;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CRC_ERR   = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  // reflected crc32, one byte
  function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] c_in,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic type_known(input logic [BYTE_W-1:0] t);
    return (t == TYPE_CMD) || (t == TYPE_DATA) || (t == TYPE_STATUS) ||
           (t == TYPE_LOG) || (t == TYPE_EXT_A) || (t == TYPE_EXT_B);
  endfunction

  // crc state right after the sync word
  localparam logic [CRC_W-1:0] MAGIC_CRC =
    crc32_byte(crc32_byte(crc32_byte(crc32_byte(CRC_INIT, SYNC_A), SYNC_B), SYNC_A), SYNC_B);

endpackage

### hdl/crcfr_in_if.sv
// ----------------------------------------------------------------------------
// crcfr_in_if
// Input channel: one received byte or one time tick per item.
// ----------------------------------------------------------------------------
interface crcfr_in_if;
  import crcfr_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

### hdl/crcfr_out_if.sv
// ----------------------------------------------------------------------------
// crcfr_out_if
// Result channel: payload byte items and frame end status items.
// ----------------------------------------------------------------------------
interface crcfr_out_if;
  import crcfr_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] data_byte;
  logic [IDX_W-1:0]  byte_index;
  status_t           status;
  logic [BYTE_W-1:0] frame_type;
  logic [SEQ_W-1:0]  seq;
  logic [PLEN_W-1:0] payload_len;
  logic              last;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output status, output frame_type, output seq, output payload_len,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_index,
                  input status, input frame_type, input seq, input payload_len,
                  input last, output ready);
endinterface

### hdl/crc_framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// crc_framed_packet_receiver
// Hunts for the 55 AA 55 AA sync word, parses the header, streams the payload
// and checks the trailing reflected CRC32; reports each frame end with status.
// ----------------------------------------------------------------------------
// Takes one item (a received byte or a time tick) every clock cycle while the
// output is not stalled. An item lands in an input register, combinational logic
// (a byte-wide CRC32 update and the phase step) updates the frame state, and the
// result goes to an output register. The input side keeps accepting while a
// result waits on the output, until both registers are full. Payload bytes come
// out as they arrive and are only good if the closing end item says ok. There is
// no clearing pass after reset.
module crc_framed_packet_receiver #(
  parameter int unsigned MAX_PAYLOAD = crcfr_pkg::DEFAULT_MAX_PAYLOAD
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [crcfr_pkg::CFG_W-1:0]  cfg_wdata,
  crcfr_in_if.sink                     in_item,
  crcfr_out_if.source                  out_item
);
  import crcfr_pkg::*;

  localparam int unsigned CNT_W = ($clog2(MAX_PAYLOAD + 1) > 3) ? $clog2(MAX_PAYLOAD + 1) : 3;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);
  localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(6);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HDR,
    PH_PAY,
    PH_CRC
  } phase_t;

  // control state
  phase_t            phase_r, phase_nxt;
  logic [31:0]       window_r, window_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [BYTE_W-1:0] ftype_r, ftype_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [CRC_W-1:0]  rcrc_r, rcrc_nxt;
  logic [GAP_W-1:0]  gap_r, gap_nxt;
  logic [CFG_W-1:0]  stall_limit_r;
  logic              in_valid_r;
  logic              out_valid_r;

  // payload registers
  logic              in_action_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              o_kind_r;
  logic [BYTE_W-1:0] o_data_r;
  logic [IDX_W-1:0]  o_index_r;
  status_t           o_status_r;
  logic [BYTE_W-1:0] o_type_r;
  logic [SEQ_W-1:0]  o_seq_r;
  logic [PLEN_W-1:0] o_plen_r;

  // combinational results
  logic              out_load_ok;
  logic              fire;
  logic              emit;
  logic              end_req;
  status_t           end_status;
  logic              end_hdr;
  logic              r_kind;
  logic [BYTE_W-1:0] r_data;
  logic [IDX_W-1:0]  r_index;
  status_t           r_status;
  logic [BYTE_W-1:0] r_type;
  logic [SEQ_W-1:0]  r_seq;
  logic [PLEN_W-1:0] r_plen;
  logic [GAP_W-1:0]  gap_inc;
  logic [CNT_W-1:0]  cnt_inc;
  logic [LEN_W-1:0]  cnt_ext;
  logic [LEN_W-1:0]  hdr_len;
  logic [CRC_W-1:0]  crc_upd;

  assign out_load_ok = !out_valid_r || out_item.ready;
  assign fire        = in_valid_r && out_load_ok;

  assign in_item.ready = !in_valid_r || out_load_ok;

  assign gap_inc = (gap_r == {GAP_W{1'b1}}) ? gap_r : gap_r + GAP_W'(1);
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign cnt_ext = LEN_W'(cnt_r);
  assign hdr_len = {in_byte_r, len_r[7:0]};
  assign crc_upd = crc32_byte(crc_r, in_byte_r);

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    cnt_nxt    = cnt_r;
    seq_nxt    = seq_r;
    ftype_nxt  = ftype_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    rcrc_nxt   = rcrc_r;
    gap_nxt    = gap_r;
    emit       = 1'b0;
    end_req    = 1'b0;
    end_status = ST_OK;
    end_hdr    = 1'b0;
    r_kind     = KIND_PAYLOAD;
    r_data     = '0;
    r_index    = '0;
    r_status   = ST_OK;
    r_type     = '0;
    r_seq      = '0;
    r_plen     = '0;

    if (in_action_r == ACT_TICK) begin
      if ((stall_limit_r != '0) && (gap_inc > GAP_W'(stall_limit_r))) begin
        end_req    = 1'b1;
        end_status = ST_TRUNCATED;
        end_hdr    = (phase_r == PH_PAY) || (phase_r == PH_CRC);
      end else begin
        gap_nxt = gap_inc;
      end
    end else begin
      gap_nxt = '0;
      unique case (phase_r)
        PH_HUNT: begin
          window_nxt = {window_r[23:0], in_byte_r};
          if ({window_r[23:0], in_byte_r} == MAGIC) begin
            crc_nxt   = MAGIC_CRC;
            phase_nxt = PH_HDR;
            cnt_nxt   = '0;
            seq_nxt   = '0;
            ftype_nxt = '0;
            len_nxt   = '0;
            rcrc_nxt  = '0;
          end
        end
        PH_HDR: begin
          crc_nxt = crc_upd;
          case (cnt_r[2:0])
            3'd0, 3'd1, 3'd2, 3'd3: seq_nxt[8*cnt_r[1:0] +: 8] = in_byte_r;
            3'd4:                   ftype_nxt = in_byte_r;
            3'd5:                   len_nxt = {8'h00, in_byte_r};
            default:                len_nxt = hdr_len;
          endcase
          if (cnt_r == HDR_LAST) begin
            cnt_nxt = '0;
            if (!type_known(ftype_r)) begin
              // resync on the tail of the rejected header
              window_nxt = {seq_r[31:24], ftype_r, len_r[7:0], in_byte_r};
              phase_nxt  = PH_HUNT;
            end else if (hdr_len > MAX_LEN) begin
              end_req    = 1'b1;
              end_status = ST_TOO_LONG;
              end_hdr    = 1'b1;
            end else begin
              phase_nxt = (hdr_len == '0) ? PH_CRC : PH_PAY;
            end
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_PAY: begin
          crc_nxt = crc_upd;
          emit    = 1'b1;
          r_kind  = KIND_PAYLOAD;
          r_data  = in_byte_r;
          r_index = cnt_ext[IDX_W-1:0];
          if (LEN_W'(cnt_inc) >= len_r) begin
            cnt_nxt   = '0;
            phase_nxt = PH_CRC;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_CRC: begin
          rcrc_nxt[8*cnt_r[1:0] +: 8] = in_byte_r;
          if (cnt_r[1:0] == 2'd3) begin
            end_req    = 1'b1;
            end_status = (~crc_r == rcrc_nxt) ? ST_OK : ST_CRC_ERR;
            end_hdr    = 1'b1;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: ;
      endcase
    end

    // any frame end drops back to hunting
    if (end_req) begin
      emit       = 1'b1;
      r_kind     = KIND_END;
      r_status   = end_status;
      r_type     = end_hdr ? ftype_nxt : '0;
      r_seq      = end_hdr ? seq_nxt : '0;
      r_plen     = (end_status == ST_OK) ? len_r[PLEN_W-1:0] : '0;
      phase_nxt  = PH_HUNT;
      window_nxt = '0;
      cnt_nxt    = '0;
      gap_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      window_r      <= '0;
      cnt_r         <= '0;
      seq_r         <= '0;
      ftype_r       <= '0;
      len_r         <= '0;
      crc_r         <= CRC_INIT;
      rcrc_r        <= '0;
      gap_r         <= '0;
      stall_limit_r <= STALL_LIMIT_RESET;
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        stall_limit_r <= cfg_wdata;
      end
      if (in_item.ready) begin
        in_valid_r <= in_item.valid;
      end
      if (out_load_ok) begin
        out_valid_r <= fire && emit;
      end
      if (fire) begin
        phase_r  <= phase_nxt;
        window_r <= window_nxt;
        cnt_r    <= cnt_nxt;
        seq_r    <= seq_nxt;
        ftype_r  <= ftype_nxt;
        len_r    <= len_nxt;
        crc_r    <= crc_nxt;
        rcrc_r   <= rcrc_nxt;
        gap_r    <= gap_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      in_action_r <= in_item.action;
      in_byte_r   <= in_item.rx_byte;
    end
    if (fire && emit) begin
      o_kind_r   <= r_kind;
      o_data_r   <= r_data;
      o_index_r  <= r_index;
      o_status_r <= r_status;
      o_type_r   <= r_type;
      o_seq_r    <= r_seq;
      o_plen_r   <= r_plen;
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.kind        = o_kind_r;
  assign out_item.data_byte   = o_data_r;
  assign out_item.byte_index  = o_index_r;
  assign out_item.status      = o_status_r;
  assign out_item.frame_type  = o_type_r;
  assign out_item.seq         = o_seq_r;
  assign out_item.payload_len = o_plen_r;
  assign out_item.last        = o_kind_r;

endmodule

### tb/crcfr_frame_checker.sv
// ----------------------------------------------------------------------------
// crcfr_frame_checker
// Watches both channels of the framed packet receiver, predicts every result
// item from the accepted input items and compares field by field.
// ----------------------------------------------------------------------------
module crcfr_frame_checker
  import crcfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  crcfr_in_if               in_mon,
  crcfr_out_if              out_mon,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    STAGE_HUNT,
    STAGE_HEADER,
    STAGE_PAYLOAD,
    STAGE_TRAILER
  } stage_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  byte_index;
    status_t           status;
    logic [BYTE_W-1:0] frame_type;
    logic [SEQ_W-1:0]  seq;
    logic [PLEN_W-1:0] payload_len;
    logic              last;
  } rx_result_t;

  rx_result_t        expected_items[$];

  logic [CFG_W-1:0]  tick_limit;
  stage_t            stage;
  logic [31:0]       sync_reg;
  logic [PLEN_W-1:0] pos;
  logic [SEQ_W-1:0]  hdr_seq;
  logic [BYTE_W-1:0] hdr_type;
  logic [LEN_W-1:0]  hdr_len;
  logic [CRC_W-1:0]  crc_acc;
  logic [CRC_W-1:0]  crc_rx;
  logic [GAP_W-1:0]  idle_ticks;

  function automatic logic [CRC_W-1:0] crc_after_byte(logic [CRC_W-1:0] c,
                                                      logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic close_frame(status_t st, bit hdr_done);
    rx_result_t r;
    r.kind        = KIND_END;
    r.data_byte   = '0;
    r.byte_index  = '0;
    r.status      = st;
    r.frame_type  = hdr_done ? hdr_type : '0;
    r.seq         = hdr_done ? hdr_seq : '0;
    r.payload_len = (st == ST_OK) ? hdr_len[PLEN_W-1:0] : '0;
    r.last        = 1'b1;
    expected_items.push_back(r);
    stage      = STAGE_HUNT;
    sync_reg   = '0;
    pos        = '0;
    idle_ticks = '0;
  endtask

  task automatic absorb_item(action_t act, logic [BYTE_W-1:0] b);
    rx_result_t r;
    if (act == ACT_TICK) begin
      if (idle_ticks != '1) idle_ticks++;
      if (tick_limit != 0 && idle_ticks > tick_limit) begin
        close_frame(ST_TRUNCATED, stage == STAGE_PAYLOAD || stage == STAGE_TRAILER);
      end
    end else begin
      idle_ticks = '0;
      case (stage)
        STAGE_HUNT: begin
          sync_reg = {sync_reg[23:0], b};
          if (sync_reg == MAGIC) begin
            crc_acc = CRC_INIT;
            for (int k = 3; k >= 0; k--) crc_acc = crc_after_byte(crc_acc, MAGIC[8*k +: 8]);
            stage    = STAGE_HEADER;
            pos      = '0;
            hdr_seq  = '0;
            hdr_type = '0;
            hdr_len  = '0;
            crc_rx   = '0;
          end
        end
        STAGE_HEADER: begin
          crc_acc = crc_after_byte(crc_acc, b);
          if (pos < 4) hdr_seq[{pos[1:0], 3'b000} +: 8] = b;
          else if (pos == 4) hdr_type = b;
          else if (pos == 5) hdr_len[7:0] = b;
          else hdr_len[15:8] = b;
          pos++;
          if (pos == 7) begin
            if (!(hdr_type inside {TYPE_CMD, TYPE_DATA, TYPE_STATUS, TYPE_LOG,
                                   TYPE_EXT_A, TYPE_EXT_B})) begin
              // unknown type: last four header bytes go back into the sync window
              sync_reg = {hdr_seq[31:24], hdr_type, hdr_len[7:0], hdr_len[15:8]};
              stage    = STAGE_HUNT;
              pos      = '0;
            end else if (hdr_len > DEFAULT_MAX_PAYLOAD) begin
              close_frame(ST_TOO_LONG, 1'b1);
            end else begin
              pos   = '0;
              stage = (hdr_len == 0) ? STAGE_TRAILER : STAGE_PAYLOAD;
            end
          end
        end
        STAGE_PAYLOAD: begin
          crc_acc       = crc_after_byte(crc_acc, b);
          r.kind        = KIND_PAYLOAD;
          r.data_byte   = b;
          r.byte_index  = pos[IDX_W-1:0];
          r.status      = ST_OK;
          r.frame_type  = '0;
          r.seq         = '0;
          r.payload_len = '0;
          r.last        = 1'b0;
          expected_items.push_back(r);
          pos++;
          if (pos >= hdr_len) begin
            pos   = '0;
            stage = STAGE_TRAILER;
          end
        end
        default: begin
          crc_rx[{pos[1:0], 3'b000} +: 8] = b;
          pos++;
          if (pos == 4) close_frame((~crc_acc == crc_rx) ? ST_OK : ST_CRC_ERR, 1'b1);
        end
      endcase
    end
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    rx_result_t w;
    if (expected_items.size() == 0) begin
      $error("result item with nothing expected: kind %0d data %0h status %0d",
             out_mon.kind, out_mon.data_byte, out_mon.status);
      fail_count++;
    end else begin
      w = expected_items.pop_front();
      check_field("kind", w.kind, out_mon.kind);
      check_field("data_byte", w.data_byte, out_mon.data_byte);
      check_field("byte_index", w.byte_index, out_mon.byte_index);
      check_field("status", w.status, out_mon.status);
      check_field("frame_type", w.frame_type, out_mon.frame_type);
      check_field("seq", w.seq, out_mon.seq);
      check_field("payload_len", w.payload_len, out_mon.payload_len);
      check_field("last", w.last, out_mon.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_limit = STALL_LIMIT_RESET;
      stage      = STAGE_HUNT;
      sync_reg   = '0;
      pos        = '0;
      hdr_seq    = '0;
      hdr_type   = '0;
      hdr_len    = '0;
      crc_acc    = CRC_INIT;
      crc_rx     = '0;
      idle_ticks = '0;
      expected_items.delete();
    end else begin
      if (cfg_we) tick_limit = cfg_wdata;
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        absorb_item(action_t'(in_mon.action), in_mon.rx_byte);
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) check_result();
    end
    pending = expected_items.size();
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives framed byte streams and time ticks into the packet receiver, walks the
// stall limit through several settings and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import crcfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 100000;
  localparam logic [BYTE_W-1:0] KNOWN_TYPES [6] = '{TYPE_CMD, TYPE_DATA, TYPE_STATUS,
                                                   TYPE_LOG, TYPE_EXT_A, TYPE_EXT_B};

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             sink_ready = 1'b0;
  logic             steady = 1'b0;
  logic [CFG_W-1:0] stall_setting = STALL_LIMIT_RESET;
  int               items_sent;
  int               cycle_count;
  int               fail_count;
  int               pending;

  crcfr_in_if  in_item();
  crcfr_out_if out_item();

  assign out_item.ready = sink_ready;

  crc_framed_packet_receiver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_item  (out_item)
  );

  crcfr_frame_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_item),
    .out_mon    (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    sink_ready <= steady || ($urandom_range(99) >= 13);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [CRC_W-1:0] frame_crc_byte(logic [CRC_W-1:0] c,
                                                      logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic push_item(action_t act, logic [BYTE_W-1:0] b);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 13) begin
      in_item.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 13);
    end
    in_item.valid   <= 1'b1;
    in_item.action  <= act;
    in_item.rx_byte <= b;
    do @(posedge clk); while (in_item.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic push_byte(logic [BYTE_W-1:0] b);
    push_item(ACT_BYTE, b);
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_item(ACT_TICK, BYTE_W'($urandom_range(255)));
  endtask

  // cut >= 0 stops the frame before that byte and lets the line stall out;
  // resume_sync starts at the last magic byte, for a window reloaded by a bad type
  task automatic send_frame(logic [SEQ_W-1:0] seq, logic [BYTE_W-1:0] ftype,
                            logic [LEN_W-1:0] len, bit bad_crc, int cut, bit resume_sync);
    logic [BYTE_W-1:0] fb[$];
    logic [CRC_W-1:0]  crc;
    int                flip;
    int                hold;
    for (int k = 3; k >= 0; k--) fb.push_back(MAGIC[8*k +: 8]);
    for (int k = 0; k < 4; k++) fb.push_back(seq[8*k +: 8]);
    fb.push_back(ftype);
    fb.push_back(len[7:0]);
    fb.push_back(len[15:8]);
    if (ftype inside {TYPE_CMD, TYPE_DATA, TYPE_STATUS, TYPE_LOG, TYPE_EXT_A, TYPE_EXT_B} &&
        len <= DEFAULT_MAX_PAYLOAD) begin
      for (int i = 0; i < len; i++) fb.push_back(BYTE_W'($urandom_range(255)));
      crc = CRC_INIT;
      foreach (fb[i]) crc = frame_crc_byte(crc, fb[i]);
      crc = ~crc;
      if (bad_crc) begin
        flip = $urandom_range(31);
        crc[flip] = ~crc[flip];
      end
      for (int k = 0; k < 4; k++) fb.push_back(crc[8*k +: 8]);
    end
    hold = (stall_setting == 0 || stall_setting > 3) ? 3 : stall_setting;
    for (int i = resume_sync ? 3 : 0; i < fb.size(); i++) begin
      if (i == cut) begin
        push_ticks(stall_setting + 1);
        break;
      end
      // short tick runs that stay inside the stall limit
      if ($urandom_range(99) < 4) push_ticks($urandom_range(hold, 1));
      push_byte(fb[i]);
    end
  endtask

  task automatic random_frame();
    logic [BYTE_W-1:0] ftype;
    logic [LEN_W-1:0]  len;
    int                roll;
    int                cut;
    ftype = KNOWN_TYPES[$urandom_range(5)];
    if ($urandom_range(99) < 8) ftype = BYTE_W'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 5) len = LEN_W'($urandom_range(65535, 513));
    else if (roll < 15) len = '0;
    else len = LEN_W'($urandom_range(24, 1));
    cut = -1;
    if (stall_setting != 0 && stall_setting <= 200 && $urandom_range(99) < 10) begin
      cut = (len > DEFAULT_MAX_PAYLOAD) ? $urandom_range(10) : $urandom_range(14 + len);
    end
    // noise, often pieces of the sync word
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(4, 1)) begin
        roll = $urandom_range(2);
        push_byte(roll == 0 ? SYNC_A : roll == 1 ? SYNC_B : BYTE_W'($urandom_range(255)));
      end
    end
    send_frame($urandom, ftype, len, $urandom_range(99) < 12, cut, 1'b0);
  endtask

  task automatic random_run(int target);
    items_sent = 0;
    while (items_sent < target) random_frame();
  endtask

  task automatic drain();
    @(negedge clk);
    in_item.valid <= 1'b0;
    wait (pending == 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_stall_limit(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    stall_setting = v;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_item.valid   = 1'b0;
    in_item.action  = ACT_BYTE;
    in_item.rx_byte = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, stall limit at its reset value
    push_byte(8'h00);
    push_byte(8'hFF);
    send_frame(32'hFFFF_FFFF, TYPE_CMD, 16'd0, 1'b0, -1, 1'b0);
    send_frame(32'h0000_0000, TYPE_EXT_B, 16'd3, 1'b0, -1, 1'b0);
    send_frame(32'h1234_5678, TYPE_DATA, 16'd2, 1'b1, -1, 1'b0);
    send_frame($urandom, TYPE_STATUS, 16'd513, 1'b0, -1, 1'b0);
    send_frame($urandom, TYPE_LOG, 16'hFFFF, 1'b0, -1, 1'b0);
    // unknown type leaves A5 55 AA 55 in the window, one more AA resyncs
    send_frame(32'hA500_0001, 8'h55, 16'h55AA, 1'b0, -1, 1'b0);
    send_frame(32'h8000_0000, TYPE_DATA, 16'd5, 1'b0, -1, 1'b1);
    send_frame($urandom, TYPE_CMD, 16'd4, 1'b0, 6, 1'b0);
    send_frame($urandom, TYPE_EXT_A, 16'd4, 1'b0, 13, 1'b0);
    send_frame($urandom, TYPE_EXT_B, 16'd4, 1'b0, 17, 1'b0);
    push_ticks(100);
    push_byte(8'h5A);
    push_ticks(101);
    drain();

    write_stall_limit(16'd0);
    push_ticks(20);
    random_run(30);
    drain();

    write_stall_limit(16'd1);
    random_run(30);
    push_ticks(5);
    drain();

    write_stall_limit(16'hFFFF);
    steady = 1'b1;
    send_frame($urandom, TYPE_EXT_A, LEN_W'(DEFAULT_MAX_PAYLOAD), 1'b0, -1, 1'b0);
    random_run(15);
    steady = 1'b0;
    random_run(15);
    drain();

    write_stall_limit(CFG_W'($urandom_range(40, 2)));
    random_run(30);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
hdl/crcfr_pkg.sv
hdl/crcfr_in_if.sv
hdl/crcfr_out_if.sv
hdl/crc_framed_packet_receiver.sv
tb/crcfr_frame_checker.sv
tb/tb_top.sv
